### design/fau_pkg.sv
package fau_pkg;

    // field widths of the request and response words
    localparam int FUNC_W = 2;
    localparam int OPND_W = 16;
    localparam int NUM_W  = 32;
    localparam int DEN_W  = 30;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_ADD = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SUB = 2'd1;
    localparam logic [FUNC_W-1:0] FN_MUL = 2'd2;
    localparam logic [FUNC_W-1:0] FN_DIV = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_DEN = 2'd2;

    typedef struct packed {
        logic        [FUNC_W-1:0] func;
        logic signed [OPND_W-1:0] a_num;
        logic signed [OPND_W-1:0] a_den;
        logic signed [OPND_W-1:0] b_num;
        logic signed [OPND_W-1:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [NUM_W-1:0]  res_num;
        logic        [DEN_W-1:0]  res_den;
        logic        [STAT_W-1:0] status;
    } rsp_t;

endpackage

### design/fraction_arithmetic_unit_top.sv
// Fraction arithmetic unit: adds, subtracts, multiplies or divides two
// fractions and returns the result reduced to lowest terms with a positive
// denominator (zero comes out as 0/1).
// Request channel: req carries func and both fractions; a word is taken on a
// rising edge with req_valid high and req_stall low. req_stall is high while
// an item is being worked on, so one item is in flight at a time.
// Response channel: rsp carries res_num, res_den and status; it is held in an
// output register while rsp_stall is high, and the next request is accepted
// while that word waits. The unit only waits before writing a new result if
// the previous one has still not been taken.
// Work: decode and cross products on the one shared multiplier, then each
// Euclidean step and each of the two final divisions, all on one shared
// bit-serial divider (one quotient bit a cycle). Zero denominators and
// division by a zero fraction skip straight from decode to the result. The
// time an item takes is set by the number of GCD steps.
// Reset: clears the sequencer and the response valid; no result is pending.
module fraction_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  fau_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output fau_pkg::rsp_t rsp
);
    import fau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 2;   // product and numerator accumulator
    localparam int MW = 2 * W;       // magnitudes handled by the divider
    localparam int CW = $clog2(MW + 1);
    localparam int XW = 64;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_MUL0 = 4'd2;
    localparam logic [3:0] S_MUL1 = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_SIGN = 4'd5;
    localparam logic [3:0] S_GCHK = 4'd6;
    localparam logic [3:0] S_GDIV = 4'd7;
    localparam logic [3:0] S_QN   = 4'd8;
    localparam logic [3:0] S_QD   = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     div_cnt_reg, div_cnt_next;
    logic              out_valid_reg, out_valid_next;

    // payload state
    req_t              req_reg;
    logic signed [W:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W:0] an_next, ad_next, bn_next, bd_next;
    logic signed [PW-1:0] prod_reg, n_reg, n_next;
    logic              neg_reg, neg_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [MW-1:0]     mag_reg, mag_next, den_reg, den_next;
    logic [MW-1:0]     p_reg, p_next, q_reg, q_next, qn_reg, qn_next;
    logic [MW-1:0]     div_rem_reg, div_rem_next;
    logic [MW-1:0]     div_quo_reg, div_quo_next;
    logic [MW-1:0]     div_dvs_reg, div_dvs_next;
    rsp_t              out_reg, out_next;

    // operand decode
    logic [W+OPND_W-1:0] ext_an, ext_ad, ext_bn, ext_bd;
    logic signed [W:0]   san, sad, sbn, sbd;

    // shared multiplier
    logic signed [W:0]    mul_x, mul_y;
    logic signed [PW-1:0] mul_prod;

    // divider step
    logic [MW:0]   div_sh, div_diff;
    logic          div_ge;
    logic          div_start;
    logic [MW-1:0] div_a, div_b;

    // sign handling and result formatting
    logic signed [PW-1:0] n_abs, d_abs;
    logic signed [MW:0]   num_s;
    logic signed [XW-1:0] num_x;
    logic [XW-1:0]        den_x;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // operands read as OPERAND_WIDTH-bit two's complement, one spare bit
    assign ext_an = {{W{1'b0}}, req_reg.a_num};
    assign ext_ad = {{W{1'b0}}, req_reg.a_den};
    assign ext_bn = {{W{1'b0}}, req_reg.b_num};
    assign ext_bd = {{W{1'b0}}, req_reg.b_den};
    assign san = {ext_an[W-1], ext_an[W-1:0]};
    assign sad = {ext_ad[W-1], ext_ad[W-1:0]};
    assign sbn = {ext_bn[W-1], ext_bn[W-1:0]};
    assign sbd = {ext_bd[W-1], ext_bd[W-1:0]};

    // cross product select
    always_comb
    begin
        mul_x = an_reg;
        mul_y = bd_reg;
        unique case (state_reg)
            S_MUL0:
            begin
                mul_x = an_reg;
                mul_y = (req_reg.func == FN_MUL) ? bn_reg : bd_reg;
            end
            S_MUL1:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
            end
            S_MUL2:
            begin
                mul_x = ad_reg;
                mul_y = (req_reg.func == FN_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
        endcase
    end

    assign mul_prod = PW'(mul_x) * PW'(mul_y);

    // restoring divider, one quotient bit a cycle
    assign div_sh   = {div_rem_reg, div_quo_reg[MW-1]};
    assign div_diff = div_sh - {1'b0, div_dvs_reg};
    assign div_ge   = !div_diff[MW];

    // magnitudes of numerator and denominator
    assign n_abs = n_reg[PW-1] ? -n_reg : n_reg;
    assign d_abs = prod_reg[PW-1] ? -prod_reg : prod_reg;

    // signed numerator and wrap to the response fields
    assign num_s = neg_reg ? -$signed({1'b0, qn_reg}) : $signed({1'b0, qn_reg});
    assign num_x = XW'(num_s);
    assign den_x = XW'(div_quo_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        an_next        = an_reg;
        ad_next        = ad_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        n_next         = n_reg;
        neg_next       = neg_reg;
        st_next        = st_reg;
        mag_next       = mag_reg;
        den_next       = den_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        qn_next        = qn_reg;
        div_start      = 1'b0;
        div_a          = p_reg;
        div_b          = q_reg;

        // response taken
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                an_next  = sad[W] ? -san : san;
                ad_next  = sad[W] ? -sad : sad;
                bn_next  = sbd[W] ? -sbn : sbn;
                bd_next  = sbd[W] ? -sbd : sbd;
                neg_next = 1'b0;
                qn_next  = '0;
                if (sad == '0 || sbd == '0)
                begin
                    st_next    = ST_ZERO_DEN;
                    state_next = S_DONE;
                end
                else if (req_reg.func == FN_DIV && sbn == '0)
                begin
                    st_next    = ST_DIV_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    st_next    = ST_OK;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                n_next     = prod_reg;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (req_reg.func == FN_ADD)
                begin
                    n_next = n_reg + prod_reg;
                end
                else if (req_reg.func == FN_SUB)
                begin
                    n_next = n_reg - prod_reg;
                end
                state_next = S_SIGN;
            end
            S_SIGN:
            begin
                // prod_reg holds the denominator here
                neg_next   = n_reg[PW-1] ^ prod_reg[PW-1];
                mag_next   = n_abs[MW-1:0];
                den_next   = d_abs[MW-1:0];
                p_next     = n_abs[MW-1:0];
                q_next     = d_abs[MW-1:0];
                state_next = S_GCHK;
            end
            S_GCHK:
            begin
                div_start = 1'b1;
                if (q_reg == '0)
                begin
                    // p_reg is the gcd
                    div_a      = mag_reg;
                    div_b      = p_reg;
                    state_next = S_QN;
                end
                else
                begin
                    div_a      = p_reg;
                    div_b      = q_reg;
                    state_next = S_GDIV;
                end
            end
            S_GDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    p_next     = q_reg;
                    q_next     = div_rem_reg;
                    state_next = S_GCHK;
                end
            end
            S_QN:
            begin
                if (div_cnt_reg == '0)
                begin
                    qn_next    = div_quo_reg;
                    div_start  = 1'b1;
                    div_a      = den_reg;
                    div_b      = p_reg;
                    state_next = S_QD;
                end
            end
            S_QD:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.status = st_reg;
                    if (st_reg == ST_OK)
                    begin
                        out_next.res_num = num_x[NUM_W-1:0];
                        out_next.res_den = den_x[DEN_W-1:0];
                    end
                    else
                    begin
                        out_next.res_num = '0;
                        out_next.res_den = DEN_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // divider next state
    always_comb
    begin
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_dvs_next = div_dvs_reg;
        div_cnt_next = div_cnt_reg;
        if (div_start)
        begin
            div_rem_next = '0;
            div_quo_next = div_a;
            div_dvs_next = div_b;
            div_cnt_next = CW'(MW);
        end
        else if (div_cnt_reg != '0)
        begin
            div_rem_next = div_ge ? div_diff[MW-1:0] : div_sh[MW-1:0];
            div_quo_next = {div_quo_reg[MW-2:0], div_ge};
            div_cnt_next = div_cnt_reg - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        prod_reg    <= mul_prod;
        n_reg       <= n_next;
        neg_reg     <= neg_next;
        st_reg      <= st_next;
        mag_reg     <= mag_next;
        den_reg     <= den_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        qn_reg      <= qn_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_dvs_reg <= div_dvs_next;
        out_reg     <= out_next;
    end

    // an accepted word always goes to operand decode
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_LOAD))
        else $error("accepted word did not start decode");

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_GDIV || state_reg == S_QN || state_reg == S_QD)
            && div_cnt_reg != '0) |-> (div_dvs_reg != '0))
        else $error("divider running with zero divisor");

    // a finished remainder is below its divisor
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GDIV && div_cnt_reg == '0) |-> (div_rem_reg < div_dvs_reg))
        else $error("gcd remainder not below divisor");

    // error results read as 0/1
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK)
            |-> (out_reg.res_num == '0 && out_reg.res_den == DEN_W'(1)))
        else $error("error result not 0/1");

endmodule

### sim/tb_fraction_arithmetic_unit_top.sv
`timescale 1ns / 100ps

module tb_fraction_arithmetic_unit_top;

    import fau_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_PCT     = 7;
    localparam int TAIL_CYCLES  = 60;
    localparam int LIMIT_CYCLES = 3000000;

    localparam longint unsigned NUM_MASK = 64'hFFFF_FFFF;
    localparam longint unsigned DEN_MASK = 64'h3FFF_FFFF;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // reduced fractions still owed by the unit, oldest first
    rsp_t results_due[$];
    rsp_t due_word;
    int   idle_pct       = IDLE_PCT;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    fraction_arithmetic_unit_top #(
        .OPERAND_WIDTH(OPND_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // exact rational result, reduced by euclid, sign on the numerator
    function automatic rsp_t fraction_result(input req_t w);
        longint          an, ad, bn, bd, n, d;
        longint unsigned mag, ud, p, q, t, un;
        logic            neg;
        rsp_t            r;
        r.res_num = '0;
        r.res_den = DEN_W'(1);
        r.status  = ST_OK;
        an = $signed(w.a_num);
        ad = $signed(w.a_den);
        bn = $signed(w.b_num);
        bd = $signed(w.b_den);
        if (ad == 0 || bd == 0)
        begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (w.func == FN_DIV && bn == 0)
        begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        // move operand signs onto the numerators
        if (ad < 0)
        begin
            an = -an;
            ad = -ad;
        end
        if (bd < 0)
        begin
            bn = -bn;
            bd = -bd;
        end
        case (w.func)
            FN_ADD:
            begin
                n = an * bd + bn * ad;
                d = ad * bd;
            end
            FN_SUB:
            begin
                n = an * bd - bn * ad;
                d = ad * bd;
            end
            FN_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            default:
            begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        neg = (n < 0);
        mag = neg ? longint'(-n) : longint'(n);
        ud  = d;
        p   = mag;
        q   = ud;
        while (q != 0)
        begin
            t = p % q;
            p = q;
            q = t;
        end
        mag = mag / p;
        ud  = ud / p;
        un  = neg ? (64'd0 - mag) : mag;
        r.res_num = NUM_W'(un & NUM_MASK);
        r.res_den = DEN_W'(ud & DEN_MASK);
        return r;
    endfunction

    function automatic req_t make_word(input logic [FUNC_W-1:0] fn, input int an, input int ad,
                                       input int bn, input int bd);
        req_t w;
        w.func  = fn;
        w.a_num = an[OPND_W-1:0];
        w.a_den = ad[OPND_W-1:0];
        w.b_num = bn[OPND_W-1:0];
        w.b_den = bd[OPND_W-1:0];
        return w;
    endfunction

    // mix of full-width, small and factor-rich operands
    function automatic int pick_operand();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return int'($signed($urandom_range(0, 65535) - 32768));
        else if (sel < 75)
            return int'($urandom_range(0, 40)) - 20;
        else
            return (int'($urandom_range(1, 12)) * int'($urandom_range(1, 2700)))
                   * ($urandom_range(0, 1) ? 1 : -1);
    endfunction

    // drive one request word and wait for it to be taken
    task automatic send_word(input req_t w);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        results_due.push_back(fraction_result(w));
    endtask

    // hold off the sender until every owed result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    task automatic test_zero_denominators();
        send_word(make_word(FN_ADD, 3, 0, 1, 2));
        send_word(make_word(FN_MUL, 5, 7, 9, 0));
        // zero denominator wins over a zero divisor
        send_word(make_word(FN_DIV, 1, 0, 0, 0));
        send_word(make_word(FN_SUB, 0, 0, 0, 4));
    endtask

    task automatic test_divide_by_zero();
        send_word(make_word(FN_DIV, 7, 3, 0, 5));
        send_word(make_word(FN_DIV, -32767, -7, 0, -32767));
    endtask

    task automatic test_signs();
        send_word(make_word(FN_DIV, 3, 4, -1, 2));
        send_word(make_word(FN_ADD, 1, -3, 1, 3));
        send_word(make_word(FN_SUB, 5, 6, 10, 12));
        send_word(make_word(FN_MUL, 2, -9, 3, -4));
        send_word(make_word(FN_DIV, -6, 5, 4, -15));
    endtask

    task automatic test_extremes();
        send_word(make_word(FN_ADD, 32767, 1, 32767, 1));
        send_word(make_word(FN_SUB, -32767, 1, 32767, 1));
        send_word(make_word(FN_MUL, 32767, 1, -32767, 1));
        send_word(make_word(FN_DIV, 1, 32767, 32767, 1));
        send_word(make_word(FN_ADD, 32767, 32766, -32766, 32767));
        // most negative operand, exact negation and wrap of the fields
        send_word(make_word(FN_MUL, -32768, 1, -32768, 1));
        send_word(make_word(FN_ADD, -32768, -32768, 1, 1));
        send_word(make_word(FN_MUL, 1, -32768, 1, -32768));
        send_word(make_word(FN_ADD, -32768, 1, -32768, 1));
        send_word(make_word(FN_DIV, -32768, 32767, -32768, -1));
        send_word(make_word(FN_SUB, 0, -32768, 0, 32767));
    endtask

    // random operands with some malformed words mixed in
    task automatic test_random_mix(input int count);
        req_t w;
        int   sel;
        for (int i = 0; i < count; i++)
        begin
            w = make_word(FUNC_W'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                          pick_operand(), pick_operand());
            sel = $urandom_range(0, 99);
            if (sel < 4)
                w.a_den = '0;
            else if (sel < 8)
                w.b_den = '0;
            else if (sel < 13)
            begin
                w.func  = FN_DIV;
                w.b_num = '0;
            end
            else if (w.a_den == 0 || w.b_den == 0)
                w.b_den = 1;
            send_word(w);
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_pct = 0;
        test_random_mix(count);
        idle_pct = IDLE_PCT;
    endtask

    task automatic test_drain_and_resume(input int count);
        drain_results();
        test_random_mix(count);
    endtask

    // result checker and receiver back-pressure
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result word num=%0d den=%0d status=%0d",
                         $time, rsp.res_num, rsp.res_den, rsp.status);
                mismatch_count++;
            end
            else
            begin
                due_word = results_due.pop_front();
                if (rsp.res_num !== due_word.res_num)
                begin
                    $display("%0t: res_num expected %0d actual %0d",
                             $time, due_word.res_num, rsp.res_num);
                    mismatch_count++;
                end
                if (rsp.res_den !== due_word.res_den)
                begin
                    $display("%0t: res_den expected %0d actual %0d",
                             $time, due_word.res_den, rsp.res_den);
                    mismatch_count++;
                end
                if (rsp.status !== due_word.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, due_word.status, rsp.status);
                    mismatch_count++;
                end
            end
        end
        rsp_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_fraction_arithmetic_unit_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_denominators();
        test_divide_by_zero();
        test_signs();
        test_extremes();
        test_random_mix(200);
        test_back_to_back(90);
        test_drain_and_resume(80);

        // let the last results come home
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_fraction_arithmetic_unit_top: done, clean");
        else
            $display("tb_fraction_arithmetic_unit_top: done, errors");
        $finish;
    end

endmodule
